@@ src/sacl_pkg.sv @@
// Shared types and constants for the set-associative cache tag store.
`default_nettype none

package sacl_pkg;

    localparam int ADDR_W      = 9;
    localparam int SETS        = 4;
    localparam int WAYS        = 2;
    localparam int BLOCK_BYTES = 8;

    localparam int OFF_W   = $clog2(BLOCK_BYTES);
    localparam int SET_W   = $clog2(SETS);
    localparam int WAY_W   = $clog2(WAYS);
    localparam int TAG_W   = ADDR_W - OFF_W - SET_W;
    localparam int ENTRY_W = 3;
    localparam int CNT_W   = 32;

    localparam int CAC_W = 8;
    localparam int MAC_W = 10;
    localparam logic [CAC_W-1:0] CAC_RESET = CAC_W'(1);
    localparam logic [MAC_W-1:0] MAC_RESET = MAC_W'(100);

    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    // register index, taken from paddr[2]
    localparam logic REG_CACHE_COST  = 1'b0;
    localparam logic REG_MEMORY_COST = 1'b1;

    typedef struct packed {
        logic [TAG_W-1:0] tag;
        logic [CNT_W-1:0] stamp;
    } way_entry_t;

    typedef way_entry_t [WAYS-1:0] row_t;

    typedef struct packed {
        logic             hit;
        logic [WAY_W-1:0] way;
    } way_sel_t;

endpackage

`default_nettype wire

@@ src/sacl_ifs.sv @@
// Request and response channel interfaces.
`default_nettype none

interface sacl_req_if import sacl_pkg::*;;
    logic              valid;
    logic              ready;
    logic [ADDR_W-1:0] address;

    modport source (output valid, output address, input ready);
    modport sink   (input valid, input address, output ready);
endinterface

interface sacl_rsp_if import sacl_pkg::*;;
    logic               valid;
    logic               ready;
    logic               hit;
    logic [SET_W-1:0]   set_num;
    logic [WAY_W-1:0]   way;
    logic [ENTRY_W-1:0] entry_index;
    logic [CNT_W-1:0]   hit_total;
    logic [CNT_W-1:0]   miss_total;
    logic [CNT_W-1:0]   cycle_total;

    modport source (output valid, output hit, output set_num, output way,
                    output entry_index, output hit_total, output miss_total,
                    output cycle_total, input ready);
    modport sink   (input valid, input hit, input set_num, input way,
                    input entry_index, input hit_total, input miss_total,
                    input cycle_total, output ready);
endinterface

`default_nettype wire

@@ src/sacl_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module sacl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic                                 clk,
    input  wire logic                                 we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                     wdata,
    input  wire logic                                 re,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                     rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

@@ src/sacl_way_sel.sv @@
// Tag match across the ways of one set and replacement way choice.
`default_nettype none

module sacl_way_sel import sacl_pkg::*; (
    input  wire row_t             row,
    input  wire logic [WAYS-1:0]  valid,
    input  wire logic [TAG_W-1:0] tag,
    output way_sel_t              sel
);

    logic             hit;
    logic [WAY_W-1:0] hit_way;
    logic             any_free;
    logic [WAY_W-1:0] free_way;
    logic [WAY_W-1:0] old_way;
    logic [CNT_W-1:0] old_stamp;

    always_comb
    begin
        hit      = 1'b0;
        hit_way  = '0;
        any_free = 1'b0;
        free_way = '0;
        for (int w = WAYS - 1; w >= 0; w--)
        begin
            if (valid[w] && row[w].tag == tag)
            begin
                hit     = 1'b1;
                hit_way = WAY_W'(w);
            end
            if (!valid[w])
            begin
                any_free = 1'b1;
                free_way = WAY_W'(w);
            end
        end

        // strict less-than: ties stay with the lower way
        old_way   = '0;
        old_stamp = row[0].stamp;
        for (int w = 1; w < WAYS; w++)
        begin
            if (row[w].stamp < old_stamp)
            begin
                old_way   = WAY_W'(w);
                old_stamp = row[w].stamp;
            end
        end

        sel.hit = hit;
        if (hit)
        begin
            sel.way = hit_way;
        end
        else if (any_free)
        begin
            sel.way = free_way;
        end
        else
        begin
            sel.way = old_way;
        end
    end

endmodule

`default_nettype wire

@@ src/set_assoc_cache_lru_tags_core.sv @@
// Set-associative cache tag store with LRU replacement: top level.
//
// Usage:
//   req carries one byte address per beat; rsp returns one beat per request
//   with hit flag, set, way, flat entry number and the running hit, miss and
//   cycle-cost totals (all 32-bit, wrapping).
//   The APB port holds the per-access cost (offset 0x0) and the extra miss
//   cost (offset 0x4); write them only while no request is in flight.
// Timing:
//   A request accepted in ST_IDLE reads its set row into the RAM's registered
//   read data; in ST_LOOKUP the row is checked, updated and written back as
//   the response beat becomes valid. req.ready is high only in ST_IDLE, so,
//   with the single tag RAM port pair, a request waits for the last write-back.
// Stalls:
//   The response sits in an output register. A new request is taken while it
//   waits; its update then holds until rsp.ready frees the output register.
// Reset:
//   rst_n clears all valid bits, the use clock and the counters, and loads
//   the cost registers with 1 and 100. RAM contents need no clearing.
`default_nettype none

module set_assoc_cache_lru_tags_core import sacl_pkg::*; (
    input  wire logic               clk,
    input  wire logic               rst_n,
    sacl_req_if.sink                req,
    sacl_rsp_if.source              rsp,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic      [PDATA_W-1:0] prdata,
    output logic                    pready
);

    localparam logic ST_IDLE   = 1'b0;
    localparam logic ST_LOOKUP = 1'b1;

    logic                        state_reg;
    logic                        state_next;
    logic [SET_W-1:0]            set_reg;
    logic [TAG_W-1:0]            tag_reg;
    logic [SETS-1:0][WAYS-1:0]   valid_reg;
    logic [CNT_W-1:0]            clock_reg;
    logic [CNT_W-1:0]            hits_reg;
    logic [CNT_W-1:0]            misses_reg;
    logic [CNT_W-1:0]            cost_reg;
    logic [CAC_W-1:0]            cac_reg;
    logic [MAC_W-1:0]            mac_reg;

    logic                        rsp_valid_reg;
    logic                        rsp_hit_reg;
    logic [SET_W-1:0]            rsp_set_reg;
    logic [WAY_W-1:0]            rsp_way_reg;
    logic [ENTRY_W-1:0]          rsp_entry_reg;
    logic [CNT_W-1:0]            rsp_hits_reg;
    logic [CNT_W-1:0]            rsp_misses_reg;
    logic [CNT_W-1:0]            rsp_cost_reg;

    logic                        accept;
    logic                        done;
    logic                        cfg_write;
    row_t                        row_rd;
    row_t                        row_wr;
    way_sel_t                    sel;
    logic [CNT_W-1:0]            hits_next;
    logic [CNT_W-1:0]            misses_next;
    logic [CNT_W-1:0]            cost_next;

    assign req.ready = (state_reg == ST_IDLE);
    assign accept    = req.valid && req.ready;
    assign done      = (state_reg == ST_LOOKUP) && (!rsp_valid_reg || rsp.ready);

    sacl_ram #(
        .WIDTH ($bits(row_t)),
        .DEPTH (SETS)
    ) u_tag_ram (
        .clk   (clk),
        .we    (done),
        .waddr (set_reg),
        .wdata (row_wr),
        .re    (accept),
        .raddr (req.address[OFF_W +: SET_W]),
        .rdata (row_rd)
    );

    sacl_way_sel u_way_sel (
        .row   (row_rd),
        .valid (valid_reg[set_reg]),
        .tag   (tag_reg),
        .sel   (sel)
    );

    always_comb
    begin
        row_wr                = row_rd;
        row_wr[sel.way].tag   = tag_reg;
        row_wr[sel.way].stamp = clock_reg;

        hits_next   = hits_reg + CNT_W'(sel.hit);
        misses_next = misses_reg + CNT_W'(!sel.hit);
        cost_next   = cost_reg + CNT_W'(cac_reg) + (sel.hit ? '0 : CNT_W'(mac_reg));

        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                if (done)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            valid_reg     <= '0;
            clock_reg     <= '0;
            hits_reg      <= '0;
            misses_reg    <= '0;
            cost_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (done)
            begin
                valid_reg[set_reg][sel.way] <= 1'b1;
                clock_reg                   <= clock_reg + CNT_W'(1);
                hits_reg                    <= hits_next;
                misses_reg                  <= misses_next;
                cost_reg                    <= cost_next;
                rsp_valid_reg               <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            set_reg <= req.address[OFF_W +: SET_W];
            tag_reg <= req.address[OFF_W + SET_W +: TAG_W];
        end
        if (done)
        begin
            rsp_hit_reg    <= sel.hit;
            rsp_set_reg    <= set_reg;
            rsp_way_reg    <= sel.way;
            rsp_entry_reg  <= ENTRY_W'(set_reg) * ENTRY_W'(WAYS) + ENTRY_W'(sel.way);
            rsp_hits_reg   <= hits_next;
            rsp_misses_reg <= misses_next;
            rsp_cost_reg   <= cost_next;
        end
    end

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.hit         = rsp_hit_reg;
    assign rsp.set_num     = rsp_set_reg;
    assign rsp.way         = rsp_way_reg;
    assign rsp.entry_index = rsp_entry_reg;
    assign rsp.hit_total   = rsp_hits_reg;
    assign rsp.miss_total  = rsp_misses_reg;
    assign rsp.cycle_total = rsp_cost_reg;

    // APB register file
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cac_reg <= CAC_RESET;
            mac_reg <= MAC_RESET;
        end
        else if (cfg_write)
        begin
            case (paddr[2])
                REG_CACHE_COST:  cac_reg <= pwdata[CAC_W-1:0];
                REG_MEMORY_COST: mac_reg <= pwdata[MAC_W-1:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_CACHE_COST:  prdata = PDATA_W'(cac_reg);
            REG_MEMORY_COST: prdata = PDATA_W'(mac_reg);
            default:         prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

@@ dv/testbench.sv @@
// Testbench for the set-associative LRU tag store: directed and random lookups.
`timescale 1ns / 1ps

module testbench;
    import sacl_pkg::*;

    localparam int LINES = SETS * WAYS;
    localparam int RANDOM_ACCESSES = 1350;
    localparam int SEGMENTS = 4;

    typedef struct packed {
        logic               hit;
        logic [SET_W-1:0]   set_num;
        logic [WAY_W-1:0]   way;
        logic [ENTRY_W-1:0] entry_index;
        logic [CNT_W-1:0]   hit_total;
        logic [CNT_W-1:0]   miss_total;
        logic [CNT_W-1:0]   cycle_total;
    } lookup_t;

    typedef enum logic [1:0] {RDY_ALWAYS, RDY_RANDOM, RDY_BURSTY} ready_mode_t;

    logic               clk;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    sacl_req_if req_ch ();
    sacl_rsp_if rsp_ch ();

    set_assoc_cache_lru_tags_core u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req_ch),
        .rsp     (rsp_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // predictor state
    logic             way_valid [LINES];
    logic [TAG_W-1:0] way_tag   [LINES];
    logic [CNT_W-1:0] way_stamp [LINES];
    logic [CNT_W-1:0] lru_clock;
    logic [CNT_W-1:0] hit_cnt;
    logic [CNT_W-1:0] miss_cnt;
    logic [CNT_W-1:0] cost_cnt;
    logic [CAC_W-1:0] access_cost;
    logic [MAC_W-1:0] miss_cost;

    lookup_t          pending_lookups [$];
    int               mismatches;
    int               send_burst_left;
    bit               steady_send;
    logic [TAG_W-1:0] hot_tag_base;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("testbench NOT OK");
        $finish;
    end

    function automatic lookup_t predict_lookup(input logic [ADDR_W-1:0] addr);
        lookup_t          r;
        logic [SET_W-1:0] set_sel;
        logic [TAG_W-1:0] tag;
        int               base;
        int               w;
        int               sel;
        int               oldest;
        logic [CNT_W-1:0] oldest_stamp;
        logic             found;
        set_sel = addr[OFF_W +: SET_W];
        tag     = addr[ADDR_W-1 -: TAG_W];
        base    = int'(set_sel) * WAYS;
        found   = 1'b0;
        sel     = -1;
        cost_cnt = cost_cnt + CNT_W'(access_cost);
        for (w = 0; w < WAYS; w++)
        begin
            if (!found && way_valid[base + w] && way_tag[base + w] == tag)
            begin
                found = 1'b1;
                sel = w;
            end
        end
        if (found)
        begin
            hit_cnt = hit_cnt + 1;
        end
        else
        begin
            miss_cnt = miss_cnt + 1;
            cost_cnt = cost_cnt + CNT_W'(miss_cost);
            // first invalid way, else smallest stamp with ties to the lowest way
            oldest = 0;
            oldest_stamp = way_stamp[base];
            for (w = 0; w < WAYS; w++)
            begin
                if (sel < 0)
                begin
                    if (!way_valid[base + w])
                    begin
                        sel = w;
                    end
                    else if (way_stamp[base + w] < oldest_stamp)
                    begin
                        oldest = w;
                        oldest_stamp = way_stamp[base + w];
                    end
                end
            end
            if (sel < 0)
            begin
                sel = oldest;
            end
            way_valid[base + sel] = 1'b1;
            way_tag[base + sel]   = tag;
        end
        way_stamp[base + sel] = lru_clock;
        lru_clock = lru_clock + 1;
        r.hit         = found;
        r.set_num     = set_sel;
        r.way         = WAY_W'(sel);
        r.entry_index = ENTRY_W'(base + sel);
        r.hit_total   = hit_cnt;
        r.miss_total  = miss_cnt;
        r.cycle_total = cost_cnt;
        return r;
    endfunction

    task automatic send_access(input logic [ADDR_W-1:0] addr);
        if (send_burst_left == 0)
        begin
            send_burst_left = $urandom_range(1, 20);
            if (!steady_send)
            begin
                req_ch.valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
        end
        send_burst_left--;
        req_ch.valid   <= 1'b1;
        req_ch.address <= addr;
        do @(posedge clk); while (!req_ch.ready);
        pending_lookups.push_back(predict_lookup(addr));
    endtask

    task automatic wait_drain();
        req_ch.valid <= 1'b0;
        while (pending_lookups.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_cost(input logic idx, input logic [PDATA_W-1:0] value);
        logic [PDATA_W-1:0] readback;
        logic [PDATA_W-1:0] want;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (idx == REG_CACHE_COST)
        begin
            access_cost = value[CAC_W-1:0];
        end
        else
        begin
            miss_cost = value[MAC_W-1:0];
        end
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        readback = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        want = (idx == REG_CACHE_COST) ? PDATA_W'(access_cost) : PDATA_W'(miss_cost);
        if (readback !== want)
        begin
            mismatches++;
            $display("%0t: cost reg %0d readback expected %0h got %0h",
                     $time, idx, want, readback);
        end
    endtask

    task automatic check_field(input string name, input logic [CNT_W-1:0] want,
                               input logic [CNT_W-1:0] got);
        if (got !== want)
        begin
            mismatches++;
            $display("%0t: %s expected %0h got %0h", $time, name, want, got);
        end
    endtask

    task automatic check_lookup();
        lookup_t want;
        if (pending_lookups.size() == 0)
        begin
            mismatches++;
            $display("%0t: unexpected response beat", $time);
            return;
        end
        want = pending_lookups.pop_front();
        check_field("hit", CNT_W'(want.hit), CNT_W'(rsp_ch.hit));
        check_field("set_num", CNT_W'(want.set_num), CNT_W'(rsp_ch.set_num));
        check_field("way", CNT_W'(want.way), CNT_W'(rsp_ch.way));
        check_field("entry_index", CNT_W'(want.entry_index), CNT_W'(rsp_ch.entry_index));
        check_field("hit_total", want.hit_total, rsp_ch.hit_total);
        check_field("miss_total", want.miss_total, rsp_ch.miss_total);
        check_field("cycle_total", want.cycle_total, rsp_ch.cycle_total);
    endtask

    initial
    begin
        ready_mode_t mode;
        int          mode_left;
        int          stall_left;
        logic        rdy;
        mode       = RDY_ALWAYS;
        mode_left  = 100;
        stall_left = 0;
        rsp_ch.ready <= 1'b1;
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp_ch.valid && rsp_ch.ready)
            begin
                check_lookup();
            end
            if (mode_left == 0)
            begin
                mode = ready_mode_t'($urandom_range(0, 2));
                mode_left = $urandom_range(50, 300);
            end
            mode_left--;
            case (mode)
                RDY_ALWAYS: rdy = 1'b1;
                RDY_RANDOM: rdy = ($urandom_range(0, 9) < 7);
                default:
                begin
                    if (stall_left > 0)
                    begin
                        stall_left--;
                        rdy = 1'b0;
                    end
                    else
                    begin
                        rdy = 1'b1;
                        if ($urandom_range(0, 7) == 0)
                        begin
                            stall_left = $urandom_range(1, 15);
                        end
                    end
                end
            endcase
            rsp_ch.ready <= rdy;
        end
    end

    function automatic logic [ADDR_W-1:0] pick_address();
        logic [ADDR_W-1:0] addr;
        addr = ADDR_W'($urandom);
        // mostly a small working set per set so hits and evictions both occur
        if ($urandom_range(0, 9) < 7)
        begin
            addr[ADDR_W-1 -: TAG_W] = hot_tag_base + TAG_W'($urandom_range(0, 2));
        end
        return addr;
    endfunction

    task automatic test_lru_directed();
        send_access(9'd0);
        send_access(9'd0);
        send_access(9'd7);
        send_access(9'd32);
        send_access(9'd39);
        send_access(9'd0);
        send_access(9'd64);
        send_access(9'd32);
        send_access(9'd511);
        send_access(9'd504);
        send_access(9'd24);
        send_access(9'd8);
        send_access(9'h155);
        send_access(9'h0AA);
        wait_drain();
    endtask

    task automatic test_cost_registers();
        write_cost(REG_CACHE_COST, 32'd0);
        write_cost(REG_MEMORY_COST, 32'd0);
        send_access(9'd64);
        send_access(9'd96);
        wait_drain();
        write_cost(REG_CACHE_COST, 32'd255);
        write_cost(REG_MEMORY_COST, 32'd1023);
        send_access(9'd96);
        send_access(9'd200);
        send_access(9'd300);
        wait_drain();
        // upper bits are dropped by the registers
        write_cost(REG_CACHE_COST, 32'hDEAD_BE5A);
        write_cost(REG_MEMORY_COST, 32'hFFFF_FC01);
        send_access(9'd300);
        send_access(9'd400);
        wait_drain();
        write_cost(REG_CACHE_COST, 32'(CAC_RESET));
        write_cost(REG_MEMORY_COST, 32'(MAC_RESET));
    endtask

    task automatic test_random_traffic();
        int seg;
        int n;
        for (seg = 0; seg < SEGMENTS; seg++)
        begin
            wait_drain();
            case (seg)
                1, 3:
                begin
                    write_cost(REG_CACHE_COST, $urandom);
                    write_cost(REG_MEMORY_COST, $urandom);
                end
                2:
                begin
                    write_cost(REG_CACHE_COST, 32'd255);
                    write_cost(REG_MEMORY_COST, 32'd0);
                end
                default: ;
            endcase
            steady_send = (seg == 2);
            for (n = 0; n < RANDOM_ACCESSES / SEGMENTS; n++)
            begin
                if ($urandom_range(0, 39) == 0)
                begin
                    hot_tag_base = TAG_W'($urandom);
                end
                if (seg == 1 && n == RANDOM_ACCESSES / 8)
                begin
                    wait_drain();
                end
                send_access(pick_address());
            end
        end
        steady_send = 1'b0;
    endtask

    initial
    begin
        int i;
        for (i = 0; i < LINES; i++)
        begin
            way_valid[i] = 1'b0;
            way_tag[i]   = '1;
            way_stamp[i] = '0;
        end
        lru_clock       = '0;
        hit_cnt         = '0;
        miss_cnt        = '0;
        cost_cnt        = '0;
        access_cost     = CAC_RESET;
        miss_cost       = MAC_RESET;
        mismatches      = 0;
        send_burst_left = 0;
        steady_send     = 1'b0;
        hot_tag_base    = '0;

        rst_n          <= 1'b0;
        req_ch.valid   <= 1'b0;
        req_ch.address <= '0;
        psel           <= 1'b0;
        penable        <= 1'b0;
        pwrite         <= 1'b0;
        paddr          <= '0;
        pwdata         <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_lru_directed();
        test_cost_registers();
        test_random_traffic();
        wait_drain();
        repeat (10) @(posedge clk);

        if (mismatches == 0)
        begin
            $display("testbench OK");
        end
        else
        begin
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule
